[hdl/tmpc_pkg.sv]
// ----------------------------------------------------------------------------
// tmpc_pkg: shared types and constants of the thermal grid-search controller
// Fixed-point constants, lookup functions and the control state type.
// ----------------------------------------------------------------------------
`default_nettype none

package tmpc_pkg;

	// Signed temperature width (Q.16 degrees C, clamped to [-2^24, 2^24-1])
	localparam int TEMP_W = 25;
	// Accumulated plan cost width (unsigned Q.16, saturating)
	localparam int COST_W = 48;
	// Pipeline depth of one step cell
	localparam int CELL_STAGES = 12;

	localparam logic signed [25:0] KELVIN_OFS  = 26'sd17901158;
	localparam logic signed [25:0] AMBIENT_Q16 = 26'sd1638400;
	localparam logic signed [28:0] TEMP_MAX    = 29'sd16777215;
	localparam logic signed [28:0] TEMP_MIN    = -29'sd16777216;

	// Reciprocal multipliers: x/5 = (x*DIV5_MUL) >> 29, x/25 = (x*DIV25_MUL) >> 32
	localparam logic [26:0] DIV5_MUL  = 27'd107374183;
	localparam logic [27:0] DIV25_MUL = 28'd171798692;

	localparam logic [COST_W-1:0] CEIL_PENALTY = 48'd655360000000;
	localparam logic [COST_W-1:0] SWITCH_COST  = 48'd983040;

	// Configuration register indexes
	localparam logic [1:0] REG_TEMP_CEILING = 2'd0;
	localparam logic [1:0] REG_COMFORT_LOW  = 2'd1;
	localparam logic [1:0] REG_COMFORT_HIGH = 2'd2;

	localparam logic signed [15:0] TEMP_CEILING_RST = 16'sd21760;
	localparam logic signed [15:0] COMFORT_LOW_RST  = 16'sd5120;
	localparam logic signed [15:0] COMFORT_HIGH_RST = 16'sd10240;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} tmpc_state_t;

	// Per-item environment broadcast to every cell
	typedef struct packed {
		logic signed [TEMP_W-1:0] ceil_lvl;
		logic signed [TEMP_W-1:0] lo_lvl;
		logic signed [TEMP_W-1:0] hi_lvl;
		logic [15:0]              prior;
	} tmpc_env_t;

	function automatic logic [4:0] pwr_watts(input logic [1:0] idx);
		logic [4:0] w;
		case (idx)
			2'd0:    w = 5'd5;
			2'd1:    w = 5'd15;
			2'd2:    w = 5'd30;
			default: w = 5'd0;
		endcase
		return w;
	endfunction

	// 5 * (30 - P)^2 in whole units
	function automatic logic [11:0] thr_cost(input logic [1:0] idx);
		logic [11:0] c;
		case (idx)
			2'd0:    c = 12'd3125;
			2'd1:    c = 12'd1125;
			default: c = 12'd0;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] eps_code(input logic sel);
		return sel ? 16'd55706 : 16'd9830;
	endfunction

	// eps * sigma * area * 2^48
	function automatic logic [20:0] rad_coef(input logic sel);
		return sel ? 21'd2034853 : 21'd359092;
	endfunction

endpackage

`default_nettype wire

[hdl/tmpc_ifs.sv]
// ----------------------------------------------------------------------------
// tmpc_ifs: channel interfaces of the thermal grid-search controller
// Sample input, decision output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmpc_sample_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] cpu_temp;
	logic [15:0]       prior_emissivity;
	modport source(output valid, cpu_temp, prior_emissivity, input ready);
	modport sink(input valid, cpu_temp, prior_emissivity, output ready);
endinterface

interface tmpc_decision_if;
	logic        valid;
	logic        ready;
	logic [4:0]  chosen_power_watts;
	logic [15:0] chosen_emissivity;
	modport source(output valid, chosen_power_watts, chosen_emissivity, input ready);
	modport sink(input valid, chosen_power_watts, chosen_emissivity, output ready);
endinterface

interface tmpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/thermal_mpc_grid_search.sv]
// Flow: an accepted item starts the plan enumerator, each plan passes the H step cells
// (H = HORIZON_STEPS), the cheapest is kept and its first action loads the decision register.
// Items are taken one at a time; the plan enumerator issues one plan per cycle into a row of
// H step cells, each a 12-stage pipeline.
// A new item is taken while the previous decision still waits in the output register.
// Reset: asynchronous, clears control state and loads the register reset values.
// ----------------------------------------------------------------------------
// thermal_mpc_grid_search: grid-search model predictive thermal controller
// Scores every power/emissivity plan and returns the first action of the cheapest.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_mpc_grid_search #(
	parameter int HORIZON_STEPS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tmpc_sample_if.sink            sample,
	tmpc_decision_if.source        decision,
	tmpc_cfg_if.sink               cfg
);

	localparam int PL_W = 3*HORIZON_STEPS + 1;
	localparam int LB   = 3*HORIZON_STEPS;

	tmpc_pkg::tmpc_state_t state_q, state_d;

	logic signed [15:0] ceil_cfg_q, lo_cfg_q, hi_cfg_q;
	logic signed [tmpc_pkg::TEMP_W-1:0] t0_q;
	logic [15:0] prior_q;
	tmpc_pkg::tmpc_env_t env;

	logic                          best_have_q;
	logic [tmpc_pkg::COST_W-1:0]   best_cost_q;
	logic [1:0]                    best_p_q;
	logic                          best_e_q;
	logic                          dvld_q;
	logic [4:0]                    dpow_q;
	logic [15:0]                   deps_q;

	logic sample_ready, gen_start, load_out;
	logic gen_vld, gen_last;
	logic [2*HORIZON_STEPS-1:0] gen_p;
	logic [HORIZON_STEPS-1:0]   gen_e;

	logic                               c_vld [0:HORIZON_STEPS];
	logic [PL_W-1:0]                    c_pln [0:HORIZON_STEPS];
	logic [tmpc_pkg::COST_W-1:0]        c_cost[0:HORIZON_STEPS];
	logic signed [tmpc_pkg::TEMP_W-1:0] c_t   [0:HORIZON_STEPS-1];

	logic fin_vld, fin_last, better;

	// Register writes; out-of-range indexes are dropped
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_cfg_q <= tmpc_pkg::TEMP_CEILING_RST;
			lo_cfg_q   <= tmpc_pkg::COMFORT_LOW_RST;
			hi_cfg_q   <= tmpc_pkg::COMFORT_HIGH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				tmpc_pkg::REG_TEMP_CEILING: ceil_cfg_q <= cfg.data;
				tmpc_pkg::REG_COMFORT_LOW:  lo_cfg_q   <= cfg.data;
				tmpc_pkg::REG_COMFORT_HIGH: hi_cfg_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		env.ceil_lvl = {ceil_cfg_q[15], ceil_cfg_q, 8'd0};
		env.lo_lvl   = {lo_cfg_q[15], lo_cfg_q, 8'd0};
		env.hi_lvl   = {hi_cfg_q[15], hi_cfg_q, 8'd0};
		env.prior    = prior_q;
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (sample.valid && sample_ready) begin
			t0_q    <= {sample.cpu_temp[15], sample.cpu_temp, 8'd0};
			prior_q <= sample.prior_emissivity;
		end
	end

	tmpc_plan_gen #(
		.HORIZON_STEPS(HORIZON_STEPS)
	) u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gen_start),
		.vld    (gen_vld),
		.last   (gen_last),
		.plan_p (gen_p),
		.plan_e (gen_e)
	);

	assign c_vld[0]  = gen_vld;
	assign c_pln[0]  = {gen_last, gen_e, gen_p};
	assign c_cost[0] = '0;
	assign c_t[0]    = t0_q;

	// Row of step cells
	for (genvar k = 0; k < HORIZON_STEPS; k++) begin : g_cell
		if (k < HORIZON_STEPS - 1) begin : g_mid
			tmpc_cell #(
				.HORIZON_STEPS(HORIZON_STEPS),
				.STEP         (k)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.env    (env),
				.vld_i  (c_vld[k]),
				.pln_i  (c_pln[k]),
				.cost_i (c_cost[k]),
				.t_i    (c_t[k]),
				.vld_o  (c_vld[k+1]),
				.pln_o  (c_pln[k+1]),
				.cost_o (c_cost[k+1]),
				.t_o    (c_t[k+1])
			);
		end else begin : g_end
			tmpc_cell #(
				.HORIZON_STEPS(HORIZON_STEPS),
				.STEP         (k)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.env    (env),
				.vld_i  (c_vld[k]),
				.pln_i  (c_pln[k]),
				.cost_i (c_cost[k]),
				.t_i    (c_t[k]),
				.vld_o  (c_vld[k+1]),
				.pln_o  (c_pln[k+1]),
				.cost_o (c_cost[k+1]),
				.t_o    ()
			);
		end
	end

	assign fin_vld  = c_vld[HORIZON_STEPS];
	assign fin_last = c_pln[HORIZON_STEPS][LB];
	assign better   = !best_have_q || (c_cost[HORIZON_STEPS] < best_cost_q);

	// Keep the first strictly cheapest plan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_have_q <= 1'b0;
		end else if (gen_start) begin
			best_have_q <= 1'b0;
		end else if (fin_vld && better) begin
			best_have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_vld && better) begin
			best_cost_q <= c_cost[HORIZON_STEPS];
			best_p_q    <= c_pln[HORIZON_STEPS][1:0];
			best_e_q    <= c_pln[HORIZON_STEPS][2*HORIZON_STEPS];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmpc_pkg::ST_IDLE:  if (sample.valid) state_d = tmpc_pkg::ST_RUN;
			tmpc_pkg::ST_RUN:   if (gen_vld && gen_last) state_d = tmpc_pkg::ST_DRAIN;
			tmpc_pkg::ST_DRAIN: if (fin_vld && fin_last) state_d = tmpc_pkg::ST_DONE;
			tmpc_pkg::ST_DONE:  if (!dvld_q || decision.ready) state_d = tmpc_pkg::ST_IDLE;
			default:            state_d = tmpc_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		sample_ready = 1'b0;
		load_out     = 1'b0;
		case (state_q)
			tmpc_pkg::ST_IDLE: sample_ready = 1'b1;
			tmpc_pkg::ST_DONE: load_out     = !dvld_q || decision.ready;
			default: ;
		endcase
	end

	assign gen_start    = sample.valid && sample_ready;
	assign sample.ready = sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmpc_pkg::ST_IDLE;
			dvld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				dvld_q <= 1'b1;
			end else if (decision.ready) begin
				dvld_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			dpow_q <= tmpc_pkg::pwr_watts(best_p_q);
			deps_q <= tmpc_pkg::eps_code(best_e_q);
		end
	end

	assign decision.valid              = dvld_q;
	assign decision.chosen_power_watts = dpow_q;
	assign decision.chosen_emissivity  = deps_q;

endmodule

`default_nettype wire

[hdl/tmpc_plan_gen.sv]
// ----------------------------------------------------------------------------
// tmpc_plan_gen: plan enumerator
// Walks power digits (base 3, step 0 most significant) in the outer order and
// emissivity bits in the inner order, one plan per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpc_plan_gen #(
	parameter int HORIZON_STEPS = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         vld,
	output logic                         last,
	output logic [2*HORIZON_STEPS-1:0]   plan_p,
	output logic [HORIZON_STEPS-1:0]     plan_e
);

	logic                     run_q;
	logic [1:0]               pdig_q [HORIZON_STEPS];
	logic [1:0]               pdig_d [HORIZON_STEPS];
	logic [HORIZON_STEPS-1:0] ecnt_q;
	logic                     carry;

	// Advance the power digits when the emissivity count wraps
	always_comb begin
		carry = &ecnt_q;
		for (int k = HORIZON_STEPS - 1; k >= 0; k--) begin
			pdig_d[k] = pdig_q[k];
			if (carry) begin
				pdig_d[k] = (pdig_q[k] == 2'd2) ? 2'd0 : pdig_q[k] + 2'd1;
			end
			carry = carry && (pdig_q[k] == 2'd2);
		end
	end

	always_comb begin
		for (int k = 0; k < HORIZON_STEPS; k++) begin
			plan_p[2*k +: 2] = pdig_q[k];
			plan_e[k]        = ecnt_q[HORIZON_STEPS-1-k];
		end
	end

	assign vld  = run_q;
	assign last = carry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ecnt_q <= '0;
			for (int k = 0; k < HORIZON_STEPS; k++) pdig_q[k] <= 2'd0;
		end else if (start) begin
			run_q  <= 1'b1;
			ecnt_q <= '0;
			for (int k = 0; k < HORIZON_STEPS; k++) pdig_q[k] <= 2'd0;
		end else if (run_q) begin
			if (carry) run_q <= 1'b0;
			ecnt_q <= ecnt_q + 1'b1;
			for (int k = 0; k < HORIZON_STEPS; k++) pdig_q[k] <= pdig_d[k];
		end
	end

endmodule

`default_nettype wire

[hdl/tmpc_cell.sv]
// ----------------------------------------------------------------------------
// tmpc_cell: one horizon step
// Pipelined Euler heat step plus step cost for one plan per cycle; hands the
// new temperature and running cost to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpc_cell #(
	parameter int HORIZON_STEPS = 5,
	parameter int STEP          = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tmpc_pkg::tmpc_env_t                  env,
	input  logic                                 vld_i,
	input  logic [3*HORIZON_STEPS:0]             pln_i,
	input  logic [tmpc_pkg::COST_W-1:0]          cost_i,
	input  logic signed [tmpc_pkg::TEMP_W-1:0]   t_i,
	output logic                                 vld_o,
	output logic [3*HORIZON_STEPS:0]             pln_o,
	output logic [tmpc_pkg::COST_W-1:0]          cost_o,
	output logic signed [tmpc_pkg::TEMP_W-1:0]   t_o
);

	localparam int PL_W = 3*HORIZON_STEPS + 1;
	localparam int NS   = tmpc_pkg::CELL_STAGES;
	localparam int EB   = 2*HORIZON_STEPS + STEP;

	// Side lines that follow the plan down the stages
	logic                               vld_s  [1:NS];
	logic [PL_W-1:0]                    pln_s  [1:NS];
	logic [tmpc_pkg::COST_W-1:0]        costl_s[1:NS-1];
	logic signed [tmpc_pkg::TEMP_W-1:0] told_s [1:7];

	logic [25:0]        tk_s1;
	logic signed [25:0] x_s1, x_s2;
	logic [51:0]        sq_s2, xq_s2;
	logic               xneg_s2;
	logic [55:0]        hh_s3;
	logic signed [27:0] cond_s3, cond_s4, cond_s5;
	logic [39:0]        diff_s4;
	logic               rneg_s4, rneg_s5;
	logic [60:0]        mag_s5;
	logic signed [31:0] net_s6;
	logic [58:0]        nq_s7;
	logic               nneg_s7;
	logic signed [tmpc_pkg::TEMP_W-1:0] tn_s8, tn_s9, tn_s10, tn_s11, tn_s12;
	logic               ceilf_s9, ceilf_s10;
	logic [24:0]        e_s9;
	logic [49:0]        ee_s10;
	logic [tmpc_pkg::COST_W-1:0] stepc_s11, cost_s12;

	logic signed [25:0] t_ext;
	logic [24:0]        xabs;
	logic [27:0]        h;
	logic [39:0]        k4;
	logic [31:0]        pw;
	logic [31:0]        rad_ext;
	logic [30:0]        nabs;
	logic signed [28:0] tsum;
	logic [26:0]        q25;
	logic [33:0]        exc;
	logic [tmpc_pkg::COST_W-1:0] exc10;
	logic [tmpc_pkg::COST_W:0]   csum;
	logic               sw;

	// Switch penalty: the first step compares against the applied emissivity
	if (STEP == 0) begin : g_first
		assign sw = tmpc_pkg::eps_code(pln_s[10][EB]) != env.prior;
	end else begin : g_next
		assign sw = pln_s[10][EB] != pln_s[10][EB-1];
	end

	always_comb begin
		t_ext   = {t_i[tmpc_pkg::TEMP_W-1], t_i};
		xabs    = x_s1[25] ? 25'(-x_s1) : 25'(x_s1);
		h       = sq_s2[51:24];
		k4      = hh_s3[55:16];
		pw      = {11'd0, tmpc_pkg::pwr_watts(pln_s[5][2*STEP +: 2]), 16'd0};
		rad_ext = {3'd0, mag_s5[60:32]};
		nabs    = net_s6[31] ? 31'(-net_s6) : 31'(net_s6);
		q25     = nq_s7[58:32];
		tsum    = nneg_s7 ? {{4{told_s[7][24]}}, told_s[7]} - $signed({2'd0, q25})
		                  : {{4{told_s[7][24]}}, told_s[7]} + $signed({2'd0, q25});
		exc     = ee_s10[49:16];
		exc10   = {11'd0, exc, 3'd0} + {13'd0, exc, 1'd0};
		csum    = {1'b0, costl_s[NS-1]} + {1'b0, stepc_s11};
	end

	// Advance the side lines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= vld_i;
			for (int i = 2; i <= NS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		pln_s[1]   <= pln_i;
		costl_s[1] <= cost_i;
		told_s[1]  <= t_i;
		for (int i = 2; i <= NS; i++) pln_s[i] <= pln_s[i-1];
		for (int i = 2; i <= NS-1; i++) costl_s[i] <= costl_s[i-1];
		for (int i = 2; i <= 7; i++) told_s[i] <= told_s[i-1];
	end

	// Radiation and conduction terms
	always_ff @(posedge clk) begin
		tk_s1   <= 26'(t_ext + tmpc_pkg::KELVIN_OFS);
		x_s1    <= t_ext - tmpc_pkg::AMBIENT_Q16;

		sq_s2   <= {26'd0, tk_s1} * {26'd0, tk_s1};
		xq_s2   <= {27'd0, xabs} * {25'd0, tmpc_pkg::DIV5_MUL};
		xneg_s2 <= x_s1[25];
		x_s2    <= x_s1;

		hh_s3   <= {28'd0, h} * {28'd0, h};
		cond_s3 <= xneg_s2 ? {{2{x_s2[25]}}, x_s2} - $signed({5'd0, xq_s2[51:29]})
		                   : {{2{x_s2[25]}}, x_s2} + $signed({5'd0, xq_s2[51:29]});

		rneg_s4 <= k4 < 40'd81;
		diff_s4 <= (k4 < 40'd81) ? 40'd81 - k4 : k4 - 40'd81;
		cond_s4 <= cond_s3;

		mag_s5  <= {21'd0, diff_s4} * {40'd0, tmpc_pkg::rad_coef(pln_s[4][EB])};
		rneg_s5 <= rneg_s4;
		cond_s5 <= cond_s4;
	end

	// Euler update: net power over Cp/dt, then clamp
	always_ff @(posedge clk) begin
		net_s6  <= rneg_s5 ? $signed(pw + rad_ext) - {{4{cond_s5[27]}}, cond_s5}
		                   : $signed(pw - rad_ext) - {{4{cond_s5[27]}}, cond_s5};
		nneg_s7 <= net_s6[31];
		nq_s7   <= {28'd0, nabs} * {31'd0, tmpc_pkg::DIV25_MUL};
		if (tsum > tmpc_pkg::TEMP_MAX) begin
			tn_s8 <= tmpc_pkg::TEMP_MAX[tmpc_pkg::TEMP_W-1:0];
		end else if (tsum < tmpc_pkg::TEMP_MIN) begin
			tn_s8 <= tmpc_pkg::TEMP_MIN[tmpc_pkg::TEMP_W-1:0];
		end else begin
			tn_s8 <= tsum[tmpc_pkg::TEMP_W-1:0];
		end
	end

	// Step cost: ceiling, comfort excursion, power, switch
	always_ff @(posedge clk) begin
		tn_s9    <= tn_s8;
		ceilf_s9 <= tn_s8 >= env.ceil_lvl;
		if (tn_s8 > env.hi_lvl) begin
			e_s9 <= 25'({tn_s8[24], tn_s8} - {env.hi_lvl[24], env.hi_lvl});
		end else if (tn_s8 < env.lo_lvl) begin
			e_s9 <= 25'({env.lo_lvl[24], env.lo_lvl} - {tn_s8[24], tn_s8});
		end else begin
			e_s9 <= '0;
		end

		tn_s10    <= tn_s9;
		ceilf_s10 <= ceilf_s9;
		ee_s10    <= {25'd0, e_s9} * {25'd0, e_s9};

		tn_s11    <= tn_s10;
		stepc_s11 <= (ceilf_s10 ? tmpc_pkg::CEIL_PENALTY : '0) + exc10
		             + {20'd0, tmpc_pkg::thr_cost(pln_s[10][2*STEP +: 2]), 16'd0}
		             + (sw ? tmpc_pkg::SWITCH_COST : '0);

		tn_s12   <= tn_s11;
		cost_s12 <= csum[tmpc_pkg::COST_W] ? '1 : csum[tmpc_pkg::COST_W-1:0];
	end

	assign vld_o  = vld_s[NS];
	assign pln_o  = pln_s[NS];
	assign cost_o = cost_s12;
	assign t_o    = tn_s12;

endmodule

`default_nettype wire
